// ===== rtl/bmi_pkg.sv =====
// ----------------------------------------------------------------------------
// bmi_pkg
// Shared types and constants for the binary modular inverse block.
// ----------------------------------------------------------------------------
package bmi_pkg;

  localparam int BMI_WIDTH = 32;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_ZERO_VALUE  = 2'd1,
    STATUS_BAD_MODULUS = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic halve_p;
    logic halve_q;
    logic sub_p;
    logic sub_q;
    logic emit;
  } bmi_cmd_t;

  typedef struct packed {
    logic err;
    logic p_even;
    logic q_even;
    logic p_eq_q;
    logic p_gt_q;
  } bmi_flags_t;

endpackage

// ===== rtl/bmi_datapath.sv =====
// ----------------------------------------------------------------------------
// bmi_datapath
// Operand, coefficient and result registers with one subtract or halve step
// per cycle.
// ----------------------------------------------------------------------------
module bmi_datapath
  import bmi_pkg::*;
#(
  parameter int WIDTH = BMI_WIDTH
) (
  input  logic             clk,
  input  bmi_cmd_t         cmd,
  input  logic [WIDTH-1:0] in_value,
  input  logic [WIDTH-1:0] in_modulus,
  output bmi_flags_t       flags,
  output logic [WIDTH-1:0] coefficient,
  output logic [WIDTH-1:0] divisor,
  output logic [1:0]       status
);

  logic [WIDTH-1:0] p;
  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] u;
  logic [WIDTH-1:0] t;
  logic [WIDTH-1:0] b;
  status_t          st;

  logic [WIDTH-1:0] u_half;
  logic [WIDTH-1:0] t_half;
  logic [WIDTH-1:0] u_minus_t;
  logic [WIDTH-1:0] t_minus_u;

  // Halving modulo an odd modulus adds the modulus to an odd value first.
  assign u_half = u[0] ? (u >> 1) + (b >> 1) + WIDTH'(1) : (u >> 1);
  assign t_half = t[0] ? (t >> 1) + (b >> 1) + WIDTH'(1) : (t >> 1);

  assign u_minus_t = (u >= t) ? (u - t) : (u - t + b);
  assign t_minus_u = (t >= u) ? (t - u) : (t - u + b);

  assign flags.err    = (st != STATUS_OK);
  assign flags.p_even = ~p[0];
  assign flags.q_even = ~q[0];
  assign flags.p_eq_q = (p == q);
  assign flags.p_gt_q = (p > q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b <= in_modulus;
      q <= in_modulus;
      t <= '0;
      if (!in_modulus[0]) begin
        st <= STATUS_BAD_MODULUS;
        p  <= '0;
        u  <= '0;
      end else if (in_value == '0) begin
        st <= STATUS_ZERO_VALUE;
        p  <= in_modulus;
        u  <= '0;
      end else begin
        st <= STATUS_OK;
        p  <= in_value;
        u  <= (in_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
      end
    end else if (cmd.halve_p) begin
      p <= p >> 1;
      u <= u_half;
    end else if (cmd.halve_q) begin
      q <= q >> 1;
      t <= t_half;
    end else if (cmd.sub_p) begin
      p <= p - q;
      u <= u_minus_t;
    end else if (cmd.sub_q) begin
      q <= q - p;
      t <= t_minus_u;
    end
    if (cmd.emit) begin
      coefficient <= u;
      divisor     <= p;
      status      <= st;
    end
  end

endmodule

// ===== rtl/bmi_controller.sv =====
// ----------------------------------------------------------------------------
// bmi_controller
// Sequences the load, subtract and halve steps and owns both handshakes.
// ----------------------------------------------------------------------------
module bmi_controller
  import bmi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bmi_flags_t flags,
  output bmi_cmd_t   cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.load = in_valid;
      end
      RUN: begin
        if (flags.err) begin
        end else if (flags.p_even) begin
          cmd.halve_p = 1'b1;
        end else if (flags.q_even) begin
          cmd.halve_q = 1'b1;
        end else if (!flags.p_eq_q) begin
          cmd.sub_p = flags.p_gt_q;
          cmd.sub_q = ~flags.p_gt_q;
        end
      end
      FINISH: begin
        cmd.emit = ~out_valid | out_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (flags.err || (!flags.p_even && !flags.q_even && flags.p_eq_q)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (cmd.emit) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/binary_modular_inverse.sv =====
// ----------------------------------------------------------------------------
// binary_modular_inverse
// Greatest common divisor and modular inverse by the binary extended Euclid
// method.
// ----------------------------------------------------------------------------
// The block takes one value and odd modulus at a time and returns the gcd of
// the two and a coefficient u in [0, modulus) with u * value congruent to the
// gcd; when the gcd is one, u is the inverse. An even or zero modulus, or a
// zero value, is flagged in the status field instead. The datapath does one
// subtract or halve step per cycle while in RUN. A request is loaded when it
// is accepted in IDLE, the steps run in RUN, and FINISH writes the result to
// the output register, waiting there while an earlier result is not yet taken.
// The next request can be taken once the result is written. Each halving
// removes one bit from one of the two operands, and each subtraction is
// followed by at least one halving, so an item needs at most 4 * WIDTH - 2
// steps. Error cases and equal operands need no steps. The result sits in
// an output register, so the next item is accepted while it waits to be
// taken.
// ----------------------------------------------------------------------------
module binary_modular_inverse
  import bmi_pkg::*;
#(
  parameter int WIDTH = BMI_WIDTH,
  localparam int IN_W  = ((2 * WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // value, modulus
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // coefficient, divisor, status
);

  bmi_cmd_t         cmd;
  bmi_flags_t       flags;
  logic [WIDTH-1:0] coefficient;
  logic [WIDTH-1:0] divisor;
  logic [1:0]       status;

  bmi_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .flags     (flags),
    .cmd       (cmd)
  );

  bmi_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_value    (s_tdata[WIDTH-1:0]),
    .in_modulus  (s_tdata[2*WIDTH-1:WIDTH]),
    .flags       (flags),
    .coefficient (coefficient),
    .divisor     (divisor),
    .status      (status)
  );

  assign m_tdata = OUT_W'({status, divisor, coefficient});

endmodule

// ===== dv/tb_binary_modular_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_modular_inverse
// Self-checking testbench for the binary modular inverse block.
// ----------------------------------------------------------------------------
// A queue of requests, first hand-picked corner cases and then random ones, is
// streamed into the block with random gaps on both sides and one long output
// stall. Every accepted request is run through a local model of the binary
// extended Euclid loop, and each result is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_binary_modular_inverse;
  import bmi_pkg::*;

  localparam int W     = BMI_WIDTH;
  localparam int IN_W  = ((2 * W + 7) / 8) * 8;
  localparam int OUT_W = ((2 * W + 2 + 7) / 8) * 8;

  typedef bit [W-1:0] word_t;

  typedef struct packed {
    word_t modulus;
    word_t value;
  } request_t;

  typedef struct packed {
    word_t   coefficient;
    word_t   divisor;
    status_t status;
  } inverse_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;  // value, modulus
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;       // coefficient, divisor, status

  request_t pending_reqs[$];
  inverse_t expected_results[$];
  inverse_t oldest;
  int       total_requests = 0;
  int       requests_accepted = 0;
  int       results_seen = 0;
  int       errors = 0;
  logic     req_fire = 1'b0;
  logic     rsp_fire = 1'b0;
  logic     long_hold = 1'b0;
  int       send_wait = 0;
  int       send_calm = 0;
  int       recv_wait = 0;
  int       recv_calm = 0;

  binary_modular_inverse #(.WIDTH(W)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic word_t halve_mod(word_t x, word_t m);
    if (!x[0]) return x >> 1;
    return (x >> 1) + (m >> 1) + 1'b1;
  endfunction

  function automatic word_t diff_mod(word_t x, word_t y, word_t m);
    if (x >= y) return x - y;
    return x - y + m;
  endfunction

  function automatic inverse_t predict_inverse(word_t value, word_t modulus);
    inverse_t r;
    word_t    p;
    word_t    q;
    word_t    u;
    word_t    t;
    r.coefficient = '0;
    r.divisor     = '0;
    r.status      = STATUS_BAD_MODULUS;
    if (!modulus[0]) return r;
    if (value == '0) begin
      r.divisor = modulus;
      r.status  = STATUS_ZERO_VALUE;
      return r;
    end
    p = value;
    q = modulus;
    u = (modulus == word_t'(1)) ? word_t'(0) : word_t'(1);
    t = '0;
    while (!p[0]) begin
      p = p >> 1;
      u = halve_mod(u, modulus);
    end
    while (p != q) begin
      if (p > q) begin
        p = p - q;
        u = diff_mod(u, t, modulus);
        do begin
          p = p >> 1;
          u = halve_mod(u, modulus);
        end while (!p[0]);
      end else begin
        q = q - p;
        t = diff_mod(t, u, modulus);
        do begin
          q = q >> 1;
          t = halve_mod(t, modulus);
        end while (!q[0]);
      end
    end
    r.coefficient = u;
    r.divisor     = p;
    r.status      = STATUS_OK;
    return r;
  endfunction

  // Mostly random waits, now and then a run of zero waits.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic add_request(word_t value, word_t modulus);
    request_t req;
    req.value   = value;
    req.modulus = modulus;
    pending_reqs.push_back(req);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_fire) begin
      if (send_wait > 0) begin
        s_tvalid <= 1'b0;
        send_wait--;
      end else if (pending_reqs.size() > 0) begin
        s_tdata   <= IN_W'(pending_reqs.pop_front());
        s_tvalid  <= 1'b1;
        send_wait = draw_wait(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold) begin
      m_tready <= 1'b0;
    end else begin
      if (rsp_fire) recv_wait = draw_wait(recv_calm);
      if (recv_wait > 0) begin
        m_tready <= 1'b0;
        recv_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
      rsp_fire <= 1'b0;
    end else begin
      req_fire <= s_tvalid && s_tready;
      rsp_fire <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_inverse(s_tdata[W-1:0], s_tdata[2*W-1:W]));
        requests_accepted++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          if (m_tdata[W-1:0] !== oldest.coefficient) begin
            $display("%0t: coefficient expected %h actual %h", $time,
                     oldest.coefficient, m_tdata[W-1:0]);
            errors++;
          end
          if (m_tdata[2*W-1:W] !== oldest.divisor) begin
            $display("%0t: divisor expected %h actual %h", $time,
                     oldest.divisor, m_tdata[2*W-1:W]);
            errors++;
          end
          if (m_tdata[2*W+1:2*W] !== oldest.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     oldest.status, m_tdata[2*W+1:2*W]);
            errors++;
          end
        end
      end
    end
  end

  // Long output stall so the block fills up and pushes back on its input.
  initial begin
    while (results_seen < 60) @(negedge clk);
    long_hold <= 1'b1;
    repeat (300) @(negedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int    kind;
    word_t value;
    word_t modulus;
    word_t factor;

    add_request(word_t'(7), word_t'(10));
    add_request(word_t'(0), word_t'(0));
    add_request(word_t'(123), word_t'(0));
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    add_request(word_t'(0), 32'hFFFF_FFFF);
    add_request(word_t'(0), word_t'(1));
    add_request(word_t'(6), word_t'(1));
    add_request(32'hFFFF_FFFF, word_t'(1));
    add_request(word_t'(1), 32'hFFFF_FFFF);
    add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(32'h8000_0000, 32'hFFFF_FFFF);
    add_request(word_t'(2), word_t'(3));
    add_request(word_t'(3), word_t'(3));
    add_request(word_t'(21), word_t'(35));
    add_request(word_t'(51), word_t'(17));
    add_request(32'hFFFF_FFFF, word_t'(3));
    add_request(32'h1234_5678, 32'h8000_0001);
    add_request(word_t'(100), word_t'(7));
    add_request(32'hAAAA_AAAA, 32'h5555_5555);
    add_request(32'h5555_5555, 32'hAAAA_AAAB);
    add_request(32'hFFFF_0000, 32'hFFFF_0001);

    for (int i = 0; i < 550; i++) begin
      kind = $urandom_range(0, 19);
      case (kind)
        0: begin
          value   = $urandom;
          modulus = $urandom & ~32'd1;
        end
        1: begin
          value   = '0;
          modulus = $urandom | 32'd1;
        end
        2, 3, 4: begin
          modulus = $urandom_range(1, 255) | 1;
          value   = ($urandom_range(0, 1) == 0) ? word_t'($urandom_range(1, 1000))
                                                 : word_t'($urandom);
        end
        5, 6, 7: begin
          factor  = $urandom_range(3, 255) | 1;
          modulus = factor * ($urandom_range(1, 16777215) | 1);
          value   = factor * $urandom_range(1, 16777215);
        end
        8, 9: begin
          modulus = $urandom | 32'd1;
          value   = $urandom_range(1, 65535);
        end
        default: begin
          modulus = $urandom | 32'd1;
          value   = $urandom;
          if (value == '0) value = word_t'(1);
        end
      endcase
      add_request(value, modulus);
    end
    total_requests = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (requests_accepted < total_requests || expected_results.size() != 0)
      @(negedge clk);
    repeat (100) @(negedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
